// ----- rtl/video_chip_line_cycle_decoder_defines.svh -----
// assertion macros shared by the raster line cycle decoder
`ifndef VIDEO_CHIP_LINE_CYCLE_DECODER_DEFINES_SVH
`define VIDEO_CHIP_LINE_CYCLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VLCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define VLCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vlcd_pkg.sv -----
// shared types and codes of the raster line cycle decoder
package vlcd_pkg;

   localparam int LINE_CYCLES = 65;

   // timing standard codes
   localparam logic [1:0] MODE_PAL      = 2'd0;
   localparam logic [1:0] MODE_NTSC     = 2'd1;
   localparam logic [1:0] MODE_OLD_NTSC = 2'd2;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   // configuration register indexes
   localparam logic CSR_VIDEO_MODE    = 1'b0;
   localparam logic CSR_SCANLINE_MODE = 1'b1;

   // sprite fetch phase codes
   localparam logic [1:0] PHASE_NONE   = 2'd0;
   localparam logic [1:0] PHASE_FIRST  = 2'd1;
   localparam logic [1:0] PHASE_SECOND = 2'd2;

   // render event codes
   localparam logic [1:0] RENDER_NONE   = 2'd0;
   localparam logic [1:0] RENDER_LINE   = 2'd1;
   localparam logic [1:0] RENDER_FINISH = 2'd2;

   // line task codes
   localparam logic [2:0] TASK_NONE          = 3'd0;
   localparam logic [2:0] TASK_VC_UPDATE     = 3'd1;
   localparam logic [2:0] TASK_MC_BASE       = 3'd2;
   localparam logic [2:0] TASK_LEFT_BORDER0  = 3'd3;
   localparam logic [2:0] TASK_LEFT_BORDER1  = 3'd4;
   localparam logic [2:0] TASK_RIGHT_BORDER0 = 3'd5;
   localparam logic [2:0] TASK_RIGHT_BORDER1 = 3'd6;
   localparam logic [2:0] TASK_RC_UPDATE     = 3'd7;

   // sprite check bits
   localparam logic [2:0] CHECK_DMA     = 3'b001;
   localparam logic [2:0] CHECK_EXPAND  = 3'b010;
   localparam logic [2:0] CHECK_DISPLAY = 3'b100;

   // decoded flags of one line cycle
   typedef struct packed {
      logic [7:0] sprite_ba_mask;
      logic       background_ba;
      logic [2:0] sprite_number;
      logic [1:0] sprite_fetch_phase;
      logic       refresh_fetch;
      logic       char_fetch;
      logic       graphics_fetch;
      logic [2:0] sprite_checks;
      logic       visible_cycle;
      logic [1:0] render_event;
      logic [2:0] line_task;
      logic [5:0] sprite_x_column;
   } decode_type;

endpackage

// ----- rtl/vlcd_channels.sv -----
// request and response channel interfaces of the raster line cycle decoder
interface vlcd_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] line_cycle;

   modport source (output valid, output line_cycle, input ready);
   modport sink (input valid, input line_cycle, output ready);
endinterface

interface vlcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sprite_ba_mask;
   logic       background_ba;
   logic [2:0] sprite_number;
   logic [1:0] sprite_fetch_phase;
   logic       refresh_fetch;
   logic       char_fetch;
   logic       graphics_fetch;
   logic [2:0] sprite_checks;
   logic       visible_cycle;
   logic [1:0] render_event;
   logic [2:0] line_task;
   logic [5:0] sprite_x_column;

   modport source (
      output valid, input ready,
      output sprite_ba_mask, output background_ba, output sprite_number,
      output sprite_fetch_phase, output refresh_fetch, output char_fetch,
      output graphics_fetch, output sprite_checks, output visible_cycle,
      output render_event, output line_task, output sprite_x_column
   );
   modport sink (
      input valid, output ready,
      input sprite_ba_mask, input background_ba, input sprite_number,
      input sprite_fetch_phase, input refresh_fetch, input char_fetch,
      input graphics_fetch, input sprite_checks, input visible_cycle,
      input render_event, input line_task, input sprite_x_column
   );
endinterface

// ----- rtl/vlcd_decode.sv -----
// combinational cycle table decode and sprite x column of one line cycle
module vlcd_decode (
   input  logic [6:0]           line_cycle,
   input  logic [1:0]           video_mode,
   input  logic                 scanline_mode,
   output vlcd_pkg::decode_type result
);
   import vlcd_pkg::*;

   logic       pal;
   logic       ntsc;
   logic       in_range;
   logic       fetch_en;
   logic [1:0] fetch_phase;
   logic [6:0] fetch_sum;
   logic [2:0] fetch_sprite;
   logic [10:0] fetch_mask;
   logic       skip_add;
   logic [6:0] step_count;
   logic [6:0] column_wide;
   decode_type flags;

   assign pal      = (video_mode == MODE_PAL);
   assign ntsc     = (video_mode == MODE_NTSC);
   assign in_range = (line_cycle >= 7'd1) && (line_cycle <= 7'(LINE_CYCLES));

   // cycle table
   always_comb begin
      flags       = '0;
      fetch_en    = 1'b0;
      fetch_phase = PHASE_NONE;
      fetch_sum   = '0;
      case (line_cycle) inside
         [7'd1:7'd10]: begin
            if (ntsc) begin
               if (line_cycle != 7'd10) begin
                  fetch_en = 1'b1;
                  if (line_cycle[0]) begin
                     fetch_phase = PHASE_SECOND;
                     fetch_sum   = line_cycle + 7'd5;
                  end else begin
                     fetch_phase = PHASE_FIRST;
                     fetch_sum   = line_cycle + 7'd6;
                  end
               end
            end else begin
               fetch_en = 1'b1;
               if (line_cycle[0]) begin
                  fetch_phase = PHASE_FIRST;
                  fetch_sum   = line_cycle + 7'd5;
               end else begin
                  fetch_phase = PHASE_SECOND;
                  fetch_sum   = line_cycle + 7'd4;
               end
            end
         end
         [7'd11:7'd15]: begin
            flags.refresh_fetch = 1'b1;
            flags.background_ba = (line_cycle >= 7'd12);
            if (line_cycle == 7'd14) flags.line_task = TASK_VC_UPDATE;
            flags.char_fetch = (line_cycle == 7'd15);
         end
         [7'd16:7'd54]: begin
            flags.background_ba  = 1'b1;
            flags.char_fetch     = 1'b1;
            flags.graphics_fetch = 1'b1;
            flags.visible_cycle  = 1'b1;
            if (line_cycle == 7'd16) flags.line_task = TASK_MC_BASE;
            if (line_cycle == 7'd17) flags.line_task = TASK_LEFT_BORDER0;
            if (line_cycle == 7'd18) flags.line_task = TASK_LEFT_BORDER1;
         end
         7'd55: begin
            flags.graphics_fetch = 1'b1;
            flags.visible_cycle  = 1'b1;
            if (pal) begin
               flags.sprite_checks  = CHECK_DMA;
               flags.sprite_ba_mask = 8'h01;
            end
         end
         7'd56: begin
            flags.sprite_checks  = CHECK_DMA | CHECK_EXPAND;
            flags.line_task      = TASK_RIGHT_BORDER0;
            flags.sprite_ba_mask = 8'h01;
         end
         7'd57: begin
            flags.line_task = TASK_RIGHT_BORDER1;
            if (pal) begin
               flags.sprite_ba_mask = 8'h03;
            end else begin
               flags.sprite_checks  = CHECK_DMA;
               flags.sprite_ba_mask = 8'h01;
            end
         end
         7'd58: begin
            flags.line_task = TASK_RC_UPDATE;
            if (pal) begin
               fetch_en    = 1'b1;
               fetch_phase = PHASE_FIRST;
               fetch_sum   = 7'd0;
            end else begin
               flags.sprite_ba_mask = 8'h03;
            end
            if (!ntsc) flags.sprite_checks = CHECK_DISPLAY;
         end
         [7'd59:7'd63]: begin
            fetch_en = 1'b1;
            if (pal) begin
               if (line_cycle[0]) begin
                  fetch_phase = PHASE_SECOND;
                  fetch_sum   = line_cycle - 7'd59;
               end else begin
                  fetch_phase = PHASE_FIRST;
                  fetch_sum   = line_cycle - 7'd58;
               end
            end else begin
               if (line_cycle[0]) begin
                  fetch_phase = PHASE_FIRST;
                  fetch_sum   = line_cycle - 7'd59;
               end else begin
                  fetch_phase = PHASE_SECOND;
                  fetch_sum   = line_cycle - 7'd60;
               end
            end
            if ((line_cycle == 7'd59) && ntsc) flags.sprite_checks = CHECK_DISPLAY;
         end
         7'd64: begin
            fetch_en    = 1'b1;
            fetch_phase = PHASE_SECOND;
            fetch_sum   = 7'd4;
         end
         7'd65: begin
            fetch_en    = 1'b1;
            fetch_phase = PHASE_FIRST;
            fetch_sum   = 7'd6;
         end
         default: begin
            flags = '0;
         end
      endcase

      // sprite pointer and data fetch: sprite number is the halved sum
      fetch_sprite = fetch_sum[3:1];
      fetch_mask   = (fetch_phase == PHASE_FIRST) ? (11'd3 << fetch_sprite)
                                                  : (11'd7 << fetch_sprite);
      if (fetch_en) begin
         flags.sprite_ba_mask     = fetch_mask[7:0];
         flags.sprite_number      = fetch_sprite;
         flags.sprite_fetch_phase = fetch_phase;
      end

      // line renderer: display check replaced by render events and phi2 start
      if (scanline_mode) begin
         flags.sprite_checks = flags.sprite_checks & (CHECK_DMA | CHECK_EXPAND);
         if (line_cycle == 7'd33) begin
            flags.render_event = RENDER_LINE;
         end else if (line_cycle == 7'd55) begin
            flags.render_event = RENDER_FINISH;
         end else if (line_cycle == 7'd12) begin
            flags.sprite_checks = flags.sprite_checks | CHECK_DISPLAY;
         end
      end

      // horizontal position: twelve adds of 8 reach the wrap point in every mode
      skip_add    = ntsc && (line_cycle >= 7'd62);
      step_count  = line_cycle - 7'd1 - {6'd0, skip_add};
      column_wide = (step_count < 7'd12) ? (step_count + (pal ? 7'd51 : 7'd52))
                                         : (step_count - 7'd12);
      flags.sprite_x_column = column_wide[5:0];

      result = in_range ? flags : '0;
   end
endmodule

// ----- rtl/video_chip_line_cycle_decoder.sv -----
// Raster line cycle decoder: one line cycle number in, one set of per-cycle
// action flags out. An item is taken every clock unless the response side
// stalls; each request transfer is registered, decoded by one stage of table
// logic and registered again, and the response is held until it transfers;
// the sustained rate is one item per clock, set by the single decode stage,
// while not stalled. Cycles 64 and 65 are decoded from the table in every mode;
// a cycle of 0 or above 65 gives all fields zero. Timing standard code 3
// decodes as old NTSC. There is no clearing pass after reset; the user writes
// configuration only while the block is idle, which the block does not enforce.
`include "video_chip_line_cycle_decoder_defines.svh"

module video_chip_line_cycle_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [1:0]        csr_write_data,
   vlcd_req_if.sink          req_bus,
   vlcd_rsp_if.source        rsp_bus
);
   import vlcd_pkg::*;

   logic       video_mode_ff;
   logic [1:0] video_mode_reg_ff;
   logic       scanline_mode_ff;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [6:0] s1_cycle_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   decode_type rsp_data_ff;
   decode_type decoded;
   logic       req_transfer;
   logic       rsp_free;
   logic       s1_move;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         video_mode_reg_ff <= MODE_PAL;
         scanline_mode_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_VIDEO_MODE) begin
            video_mode_reg_ff <= csr_write_data;
         end else begin
            scanline_mode_ff <= csr_write_data[0];
         end
      end
   end

   // pal flag kept for the checks below
   always_ff @(posedge clock) begin
      if (reset) begin
         video_mode_ff <= 1'b1;
      end else begin
         video_mode_ff <= (video_mode_reg_ff == MODE_PAL);
      end
   end

   // pipeline handshake
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move       = s1_valid_ff && rsp_free;
   assign req_bus.ready = !s1_valid_ff || rsp_free;
   assign req_transfer  = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_transfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in  = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_cycle_ff <= req_bus.line_cycle;
      end
   end

   vlcd_decode u_decode (
      .line_cycle    (s1_cycle_ff),
      .video_mode    (video_mode_reg_ff),
      .scanline_mode (scanline_mode_ff),
      .result        (decoded)
   );

   // result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= decoded;
      end
   end

   // response outputs
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.sprite_ba_mask     = rsp_data_ff.sprite_ba_mask;
   assign rsp_bus.background_ba      = rsp_data_ff.background_ba;
   assign rsp_bus.sprite_number      = rsp_data_ff.sprite_number;
   assign rsp_bus.sprite_fetch_phase = rsp_data_ff.sprite_fetch_phase;
   assign rsp_bus.refresh_fetch      = rsp_data_ff.refresh_fetch;
   assign rsp_bus.char_fetch         = rsp_data_ff.char_fetch;
   assign rsp_bus.graphics_fetch     = rsp_data_ff.graphics_fetch;
   assign rsp_bus.sprite_checks      = rsp_data_ff.sprite_checks;
   assign rsp_bus.visible_cycle      = rsp_data_ff.visible_cycle;
   assign rsp_bus.render_event       = rsp_data_ff.render_event;
   assign rsp_bus.line_task          = rsp_data_ff.line_task;
   assign rsp_bus.sprite_x_column    = rsp_data_ff.sprite_x_column;

   // checks
   `VLCD_ASSERT_NEXT(a_stage_moves, clock, reset, s1_move, rsp_valid_ff,
      "decoded item lost")
   `VLCD_ASSERT_NOW(a_fetch_has_mask, clock, reset,
      rsp_valid_ff && (rsp_data_ff.sprite_fetch_phase != PHASE_NONE),
      rsp_data_ff.sprite_ba_mask != 8'h00, "sprite fetch without bus request")
   `VLCD_ASSERT_NOW(a_char_in_window, clock, reset,
      rsp_valid_ff && rsp_data_ff.char_fetch,
      rsp_data_ff.visible_cycle || rsp_data_ff.refresh_fetch,
      "character fetch outside display window")
   `VLCD_ASSERT_NOW(a_refresh_no_sprite, clock, reset,
      rsp_valid_ff && rsp_data_ff.refresh_fetch && video_mode_ff,
      rsp_data_ff.sprite_fetch_phase == PHASE_NONE, "refresh collides with sprite fetch")
endmodule

// ----- bench/video_chip_line_cycle_decoder_checker.sv -----
// watches the channels of the line cycle decoder, predicts each decode and compares
module video_chip_line_cycle_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [1:0] csr_write_data,
   vlcd_req_if        req_bus,
   vlcd_rsp_if        rsp_bus,
   output int         failures,
   output int         pending
);
   import vlcd_pkg::*;

   // shadow copy of the configuration registers
   logic [1:0] video_mode;
   logic       scanline_mode;

   // decodes waiting for their response transfer, oldest first
   decode_type expected_decodes[$];

   // sprite pointer or data fetch: bus request mask, sprite and phase
   function automatic decode_type with_sprite_fetch(input decode_type d,
                                                    input logic [1:0] phase,
                                                    input logic [2:0] spr);
      decode_type r;
      logic [7:0] span;
      r = d;
      span = (phase == PHASE_FIRST) ? 8'h03 : 8'h07;
      r.sprite_ba_mask = span << spr;
      r.sprite_number = spr;
      r.sprite_fetch_phase = phase;
      return r;
   endfunction

   // per-cycle action flags for one line cycle under the given timing standard
   function automatic decode_type decode_cycle(input logic [6:0] line_cycle,
                                               input logic [1:0] mode,
                                               input logic       scan);
      decode_type d;
      logic pal;
      logic ntsc;
      int c;
      int xpos;
      int wrap;
      d = '0;
      pal = (mode == MODE_PAL);
      ntsc = (mode == MODE_NTSC);
      c = line_cycle;
      if (c >= 1 && c <= LINE_CYCLES) begin
         if (c <= 10) begin
            // sprites 3..7 at the start of the line
            if (ntsc) begin
               if (c == 10)
                  ;
               else if (c % 2 == 1)
                  d = with_sprite_fetch(d, PHASE_SECOND, 3'((c + 5) / 2));
               else
                  d = with_sprite_fetch(d, PHASE_FIRST, 3'((c + 6) / 2));
            end else begin
               if (c % 2 == 1)
                  d = with_sprite_fetch(d, PHASE_FIRST, 3'((c + 5) / 2));
               else
                  d = with_sprite_fetch(d, PHASE_SECOND, 3'((c + 4) / 2));
            end
         end else if (c <= 15) begin
            // refresh cycles
            d.refresh_fetch = 1'b1;
            if (c >= 12) d.background_ba = 1'b1;
            if (c == 14) d.line_task = TASK_VC_UPDATE;
            if (c == 15) d.char_fetch = 1'b1;
         end else if (c <= 54) begin
            // display window
            d.background_ba = 1'b1;
            d.char_fetch = 1'b1;
            d.graphics_fetch = 1'b1;
            d.visible_cycle = 1'b1;
            if (c == 16) d.line_task = TASK_MC_BASE;
            if (c == 17) d.line_task = TASK_LEFT_BORDER0;
            if (c == 18) d.line_task = TASK_LEFT_BORDER1;
         end else if (c == 55) begin
            d.graphics_fetch = 1'b1;
            d.visible_cycle = 1'b1;
            if (pal) begin
               d.sprite_checks = CHECK_DMA;
               d.sprite_ba_mask = 8'h01;
            end
         end else if (c == 56) begin
            d.sprite_checks = CHECK_DMA | CHECK_EXPAND;
            d.line_task = TASK_RIGHT_BORDER0;
            d.sprite_ba_mask = 8'h01;
         end else if (c == 57) begin
            d.line_task = TASK_RIGHT_BORDER1;
            if (pal) begin
               d.sprite_ba_mask = 8'h03;
            end else begin
               d.sprite_checks = CHECK_DMA;
               d.sprite_ba_mask = 8'h01;
            end
         end else if (c == 58) begin
            d.line_task = TASK_RC_UPDATE;
            if (pal) d = with_sprite_fetch(d, PHASE_FIRST, 3'd0);
            else d.sprite_ba_mask = 8'h03;
            if (!ntsc) d.sprite_checks = d.sprite_checks | CHECK_DISPLAY;
         end else if (c <= 63) begin
            // sprites 0..2 at the end of the line
            if (pal) begin
               if (c % 2 == 1)
                  d = with_sprite_fetch(d, PHASE_SECOND, 3'((c - 59) / 2));
               else
                  d = with_sprite_fetch(d, PHASE_FIRST, 3'((c - 58) / 2));
            end else begin
               if (c % 2 == 1)
                  d = with_sprite_fetch(d, PHASE_FIRST, 3'((c - 59) / 2));
               else
                  d = with_sprite_fetch(d, PHASE_SECOND, 3'((c - 60) / 2));
            end
            if (c == 59 && ntsc) d.sprite_checks = d.sprite_checks | CHECK_DISPLAY;
         end else if (c == 64) begin
            d = with_sprite_fetch(d, PHASE_SECOND, 3'd2);
         end else begin
            d = with_sprite_fetch(d, PHASE_FIRST, 3'd3);
         end

         // line renderer: display check replaced by phi2 start, render events added
         if (scan) begin
            d.sprite_checks = d.sprite_checks & (CHECK_DMA | CHECK_EXPAND);
            if (c == 33) d.render_event = RENDER_LINE;
            else if (c == 55) d.render_event = RENDER_FINISH;
            else if (c == 12) d.sprite_checks = d.sprite_checks | CHECK_DISPLAY;
         end

         // horizontal position walked up from the first line cycle
         xpos = pal ? 'h198 : 'h1a0;
         wrap = pal ? 'h1f8 : 'h200;
         for (int i = 1; i < c; i++) begin
            if (!(ntsc && i == 61)) xpos = xpos + 8;
            if (xpos == wrap) xpos = 0;
         end
         d.sprite_x_column = xpos[8:3];
      end
      return d;
   endfunction

   task automatic compare_field(input string field_name, input int want, input int got);
      if (want != got) begin
         failures++;
         if (failures <= 10)
            $display("decode mismatch in %s: expected %0d, got %0d", field_name, want, got);
      end
   endtask

   // track configuration, queue predictions, check each response transfer
   always @(posedge clock) begin
      decode_type want;
      logic req_taken;
      logic rsp_taken;
      req_taken = req_bus.valid && req_bus.ready;
      rsp_taken = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         expected_decodes.delete();
         failures = 0;
         pending <= 0;
         video_mode <= MODE_PAL;
         scanline_mode <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_VIDEO_MODE: video_mode <= csr_write_data;
               CSR_SCANLINE_MODE: scanline_mode <= csr_write_data[0];
               default: ;
            endcase
         end
         if (req_taken)
            expected_decodes.push_back(decode_cycle(req_bus.line_cycle, video_mode,
                                                    scanline_mode));
         if (rsp_taken) begin
            if (expected_decodes.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("response transfer with no decode expected");
            end else begin
               want = expected_decodes.pop_front();
               compare_field("sprite_ba_mask", want.sprite_ba_mask, rsp_bus.sprite_ba_mask);
               compare_field("background_ba", want.background_ba, rsp_bus.background_ba);
               compare_field("sprite_number", want.sprite_number, rsp_bus.sprite_number);
               compare_field("sprite_fetch_phase", want.sprite_fetch_phase,
                             rsp_bus.sprite_fetch_phase);
               compare_field("refresh_fetch", want.refresh_fetch, rsp_bus.refresh_fetch);
               compare_field("char_fetch", want.char_fetch, rsp_bus.char_fetch);
               compare_field("graphics_fetch", want.graphics_fetch, rsp_bus.graphics_fetch);
               compare_field("sprite_checks", want.sprite_checks, rsp_bus.sprite_checks);
               compare_field("visible_cycle", want.visible_cycle, rsp_bus.visible_cycle);
               compare_field("render_event", want.render_event, rsp_bus.render_event);
               compare_field("line_task", want.line_task, rsp_bus.line_task);
               compare_field("sprite_x_column", want.sprite_x_column,
                             rsp_bus.sprite_x_column);
            end
         end
         pending <= expected_decodes.size();
      end
   end

endmodule

// ----- bench/video_chip_line_cycle_decoder_tb.sv -----
// stimulus and verdict for the raster line cycle decoder
module video_chip_line_cycle_decoder_tb;
   import vlcd_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [1:0] csr_write_data;
   int         failures;
   int         pending;
   logic       steady;

   vlcd_req_if req_bus ();
   vlcd_rsp_if rsp_bus ();

   video_chip_line_cycle_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   video_chip_line_cycle_decoder_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .failures         (failures),
      .pending          (pending)
   );

   // idle cycles before the next transfer; none during steady stretches
   function automatic int idle_cycles();
      if (steady) return 0;
      return $urandom_range(0, 8);
   endfunction

   // one request transfer; valid stays high when no idle cycles come between
   task automatic send_cycle(input logic [6:0] line_cycle);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.line_cycle <= line_cycle;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // wait until every response is in, then let the pipeline settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // both registers, one after the other, with the block idle
   task automatic set_config(input logic [1:0] mode, input logic scan);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_VIDEO_MODE;
      csr_write_data <= mode;
      @(posedge clock);
      csr_index <= CSR_SCANLINE_MODE;
      csr_write_data <= {1'b0, scan};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly line walks, some scattered cycles including out-of-range ones
   task automatic random_phase(input int count);
      int sent;
      int start;
      int span;
      sent = 0;
      while (sent < count) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            start = $urandom_range(1, LINE_CYCLES);
            if ($urandom_range(0, 1) == 0) start = 1;
            span = $urandom_range(1, LINE_CYCLES - start + 1);
            if (span > count - sent) span = count - sent;
            for (int i = 0; i < span; i++) send_cycle(7'(start + i));
            sent += span;
         end else begin
            for (int i = 0; i < 8; i++) begin
               if ($urandom_range(0, 3) == 0) send_cycle(7'($urandom_range(0, 127)));
               else send_cycle(7'($urandom_range(1, LINE_CYCLES)));
            end
            sent += 8;
         end
      end
      steady = 1'b0;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // stimulus and verdict
   initial begin
      logic [6:0] corner_cycles[25];
      logic [1:0] phase_mode[10];
      logic       phase_scan[10];
      corner_cycles = '{7'd0, 7'd1, 7'd2, 7'd9, 7'd10, 7'd11, 7'd12, 7'd14, 7'd15,
                        7'd16, 7'd17, 7'd18, 7'd33, 7'd54, 7'd55, 7'd56, 7'd57,
                        7'd58, 7'd59, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd127};
      phase_mode = '{MODE_PAL, MODE_NTSC, MODE_OLD_NTSC, MODE_UNUSED, MODE_PAL,
                     MODE_NTSC, MODE_OLD_NTSC, MODE_UNUSED, MODE_NTSC, MODE_PAL};
      phase_scan = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      steady = 1'b0;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_VIDEO_MODE;
      csr_write_data <= MODE_PAL;
      req_bus.valid <= 1'b0;
      req_bus.line_cycle <= 7'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // corners of the line under the reset setting
      foreach (corner_cycles[i]) send_cycle(corner_cycles[i]);
      drain();

      // every timing standard with and without the line renderer
      for (int p = 0; p < 10; p++) begin
         set_config(phase_mode[p], phase_scan[p]);
         random_phase(140);
         drain();
      end

      repeat (10) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vlcd_pkg.sv
rtl/vlcd_channels.sv
rtl/vlcd_decode.sv
rtl/video_chip_line_cycle_decoder.sv
bench/video_chip_line_cycle_decoder_checker.sv
bench/video_chip_line_cycle_decoder_tb.sv
